FILE: src/indexed_array_table_engine_top_assert.svh
// Assertion macros used by the checker of the table engine.
// Every property is sampled on the rising clock edge and is off while reset is held.
`ifndef INDEXED_ARRAY_TABLE_ENGINE_TOP_ASSERT_SVH
`define INDEXED_ARRAY_TABLE_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IATE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IATE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/iate_pkg.sv
`timescale 1ns / 1ps

package iate_pkg;

    localparam int DEPTH    = 16;
    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    localparam int POS_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int CAPC_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ   = 3'd0,
        FN_INSERT = 3'd1,
        FN_WRITE  = 3'd2,
        FN_REMOVE = 3'd3,
        FN_SORT   = 3'd4,
        FN_SEARCH = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_INVALID  = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT_UP,
        CELL_SHIFT_DN,
        CELL_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   idx;
        logic               phase;
        logic [CNT_W-1:0]   count;
        t_word              value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_SEARCH
    } t_state;

endpackage

FILE: src/indexed_array_table_engine_top.sv
`timescale 1ns / 1ps

// Packed list of up to 16 signed words kept in a row of cells, one word per
// cell. Read, insert, overwrite and remove finish in the cycle the transaction
// is accepted: inserts and removes move every cell above the index by one place
// in a single step. Sort runs one odd-even compare-exchange phase per cycle
// across the cell row. Search sorts first and then probes one midpoint per
// cycle; a miss is reported once the search window is found empty.
// Each result passes a one-entry holding stage and then the output register;
// the next transaction is taken once the holding stage has emptied into the
// output register, so a stalled result in the output register does not stop
// the next operation. Capacity is written on the configuration channel, which
// is always ready; 0 acts as 1 and values above 16 act as 16.
module indexed_array_table_engine_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [iate_pkg::FUNC_W-1:0]      i_func,
    input  logic [iate_pkg::INDEX_W-1:0]     i_index,
    input  logic signed [iate_pkg::WORD_W-1:0] i_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [iate_pkg::STATUS_W-1:0]    o_status,
    output logic signed [iate_pkg::WORD_W-1:0] o_data,
    output logic [iate_pkg::COUNT_W-1:0]     o_count,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [iate_pkg::CAP_W-1:0]       i_cfg_data
);
    import iate_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_pass, n_pass;
    logic               r_search, n_search;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    t_word              r_key, n_key;

    logic               r_pend_valid;
    t_status            r_pend_status;
    t_word              r_pend_data;
    logic [COUNT_W-1:0] r_pend_count;

    logic               r_out_valid;
    t_status            r_out_status;
    t_word              r_out_data;
    logic [COUNT_W-1:0] r_out_count;

    logic               w_fire;
    logic               w_out_load;
    logic               w_res_set;
    t_status            w_res_status;
    t_word              w_res_data;
    t_cell_ctl          w_ctl;
    logic [CNT_W-1:0]   w_cap_eff;
    logic [CMP_W-1:0]   w_idx_ext;
    logic [CMP_W-1:0]   w_cnt_ext;
    logic [CMP_W-1:0]   w_cap_ext;
    logic [CNT_W:0]     w_mid_sum;
    logic [CNT_W-1:0]   w_mid_full;
    logic [POS_W-1:0]   w_mid;
    logic [POS_W-1:0]   w_rd_addr;
    t_word              w_rd_word;

    t_word              w_val  [DEPTH];
    logic               w_swap [DEPTH];

    localparam logic [CNT_W-1:0] PASS_LAST = CNT_W'(DEPTH - 1);

    // Cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left;
        t_word w_right;
        logic  w_swap_l;

        if (g == 0) begin : g_first
            assign w_left   = '0;
            assign w_swap_l = 1'b0;
        end else begin : g_inner
            assign w_left   = w_val[g-1];
            assign w_swap_l = w_swap[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_lower
            assign w_right = w_val[g+1];
        end

        iate_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_pos    (POS_W'(g)),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_swap_l (w_swap_l),
            .o_swap_r (w_swap[g]),
            .o_value  (w_val[g])
        );
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE) && !r_pend_valid;
    assign w_fire      = i_valid && o_ready;
    assign w_out_load  = r_pend_valid && (!r_out_valid || i_ready);

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_data   = r_out_data;
    assign o_count  = r_out_count;

    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = CNT_W'(1);
        end else if (CAPC_W'(r_cap) > CAPC_W'(DEPTH)) begin
            w_cap_eff = CNT_W'(DEPTH);
        end else begin
            w_cap_eff = CNT_W'(r_cap);
        end
    end

    assign w_idx_ext = CMP_W'(i_index);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_cap_ext = CMP_W'(w_cap_eff);

    // Binary search keeps a half-open window [lo, hi); the probe is
    // floor((lo + hi - 1) / 2), the same midpoint as with an inclusive upper bound.
    assign w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (CNT_W+1)'(1);
    assign w_mid_full = w_mid_sum[CNT_W:1];
    assign w_mid      = w_mid_full[POS_W-1:0];

    assign w_rd_addr = (r_state == S_SEARCH) ? w_mid : i_index[POS_W-1:0];
    assign w_rd_word = w_val[w_rd_addr];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pass       = r_pass;
        n_search     = r_search;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_key        = r_key;
        w_res_set    = 1'b0;
        w_res_status = STAT_OK;
        w_res_data   = '0;
        w_ctl.op     = CELL_HOLD;
        w_ctl.idx    = i_index[POS_W-1:0];
        w_ctl.phase  = r_pass[0];
        w_ctl.count  = r_count;
        w_ctl.value  = i_value;

        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    w_res_set = 1'b1;
                    case (t_func'(i_func))
                        FN_READ: begin
                            if (w_idx_ext < w_cnt_ext) begin
                                w_res_data = w_rd_word;
                            end else begin
                                w_res_status = STAT_INVALID;
                            end
                        end
                        FN_INSERT: begin
                            if (r_count >= w_cap_eff) begin
                                w_res_status = STAT_FULL;
                            end else if (w_idx_ext > w_cnt_ext) begin
                                w_res_status = STAT_INVALID;
                            end else begin
                                w_ctl.op = CELL_SHIFT_UP;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        FN_WRITE: begin
                            if (w_idx_ext < w_cap_ext) begin
                                w_ctl.op = CELL_WRITE;
                            end else begin
                                w_res_status = STAT_INVALID;
                            end
                        end
                        FN_REMOVE: begin
                            if (r_count == '0) begin
                                w_res_status = STAT_EMPTY;
                            end else if (w_idx_ext >= w_cnt_ext) begin
                                w_res_status = STAT_INVALID;
                            end else begin
                                w_ctl.op = CELL_SHIFT_DN;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        FN_SORT, FN_SEARCH: begin
                            if (r_count == '0) begin
                                w_res_status = STAT_EMPTY;
                            end else begin
                                w_res_set = 1'b0;
                                n_state   = S_SORT;
                                n_pass    = '0;
                                n_search  = (t_func'(i_func) == FN_SEARCH);
                                n_key     = i_value;
                            end
                        end
                        default: begin
                            w_res_status = STAT_INVALID;
                        end
                    endcase
                end
            end
            S_SORT: begin
                w_ctl.op = CELL_SORT;
                if (r_pass == PASS_LAST) begin
                    if (r_search) begin
                        n_state = S_SEARCH;
                        n_lo    = '0;
                        n_hi    = r_count;
                    end else begin
                        n_state   = S_IDLE;
                        w_res_set = 1'b1;
                    end
                end else begin
                    n_pass = r_pass + CNT_W'(1);
                end
            end
            S_SEARCH: begin
                if (r_lo >= r_hi) begin
                    n_state      = S_IDLE;
                    w_res_set    = 1'b1;
                    w_res_status = STAT_NOTFOUND;
                end else if (w_rd_word == r_key) begin
                    n_state    = S_IDLE;
                    w_res_set  = 1'b1;
                    w_res_data = WORD_W'(w_mid_full);
                end else if (w_rd_word < r_key) begin
                    n_lo = w_mid_full + CNT_W'(1);
                end else begin
                    n_hi = w_mid_full;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_cap        <= CAP_W'(DEPTH);
            r_pass       <= '0;
            r_search     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_pass   <= n_pass;
            r_search <= n_search;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (w_res_set) begin
                r_pend_valid <= 1'b1;
            end else if (w_out_load) begin
                r_pend_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_key <= n_key;
        if (w_res_set) begin
            r_pend_status <= w_res_status;
            r_pend_data   <= w_res_data;
            r_pend_count  <= COUNT_W'(n_count);
        end
        if (w_out_load) begin
            r_out_status <= r_pend_status;
            r_out_data   <= r_pend_data;
            r_out_count  <= r_pend_count;
        end
    end

endmodule

FILE: src/iate_cell.sv
`timescale 1ns / 1ps

module iate_cell (
    input  logic                          i_clk,
    input  iate_pkg::t_cell_ctl           i_ctl,
    input  logic [iate_pkg::POS_W-1:0]    i_pos,
    input  iate_pkg::t_word               i_left,
    input  iate_pkg::t_word               i_right,
    input  logic                          i_swap_l,
    output logic                          o_swap_r,
    output iate_pkg::t_word               o_value
);
    import iate_pkg::*;

    t_word             r_value;
    t_word             n_value;
    logic [CNT_W-1:0]  w_next_pos;
    logic              w_pair_left;

    // During a sort phase this cell is the lower half of a pair when its
    // position parity matches the phase and the upper partner holds an item.
    assign w_next_pos  = CNT_W'(i_pos) + CNT_W'(1);
    assign w_pair_left = (i_pos[0] == i_ctl.phase) && (w_next_pos < i_ctl.count);
    assign o_swap_r    = (i_ctl.op == CELL_SORT) && w_pair_left && (i_right < r_value);
    assign o_value     = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_WRITE: begin
                if (i_pos == i_ctl.idx) begin
                    n_value = i_ctl.value;
                end
            end
            CELL_SHIFT_UP: begin
                if (i_pos == i_ctl.idx) begin
                    n_value = i_ctl.value;
                end else if (i_pos > i_ctl.idx) begin
                    n_value = i_left;
                end
            end
            CELL_SHIFT_DN: begin
                if (i_pos >= i_ctl.idx) begin
                    n_value = i_right;
                end
            end
            CELL_SORT: begin
                if (i_swap_l) begin
                    n_value = i_left;
                end else if (o_swap_r) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: src/iate_checker.sv
`timescale 1ns / 1ps

`include "indexed_array_table_engine_top_assert.svh"

module iate_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [iate_pkg::STATUS_W-1:0]      o_status,
    input logic signed [iate_pkg::WORD_W-1:0] o_data,
    input logic [iate_pkg::COUNT_W-1:0]       o_count
);
    import iate_pkg::*;

    // A waiting result transaction must stay offered.
    `IATE_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")

    // Every failing status carries a zero data word.
    `IATE_ASSERT_SAME(a_err_zero, o_valid && (o_status != STAT_OK), o_data == '0, "error with data")

    // An empty status can only come from an empty list, and a miss from a nonempty one.
    `IATE_ASSERT_SAME(a_empty_cnt, o_valid && (o_status == STAT_EMPTY), o_count == '0, "empty with items")
    `IATE_ASSERT_SAME(a_miss_cnt, o_valid && (o_status == STAT_NOTFOUND), o_count != '0, "miss on empty list")

endmodule

bind indexed_array_table_engine_top iate_checker u_iate_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status),
    .o_data   (o_data),
    .o_count  (o_count)
);
